// ===== sv/adc_dac_frame_converter_defines.svh =====
// ----------------------------------------------------------------
// adc_dac_frame_converter_defines: assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in rst
// ----------------------------------------------------------------
`ifndef ADC_DAC_FRAME_CONVERTER_DEFINES_SVH
`define ADC_DAC_FRAME_CONVERTER_DEFINES_SVH

// property that must hold at every edge
`define AFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent at one edge implies consequent at the next
`define AFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/afc_pkg.sv =====
// ----------------------------------------------------------------
// afc_pkg: shared types and constants
// operation codes, queue entry layout and scaling constants
// ----------------------------------------------------------------
package afc_pkg;

  // input item kinds
  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // result kinds
  localparam logic [1:0] RK_ADC = 2'd0;
  localparam logic [1:0] RK_DAC = 2'd1;
  localparam logic [1:0] RK_TX  = 2'd2;

  // descriptor high nibbles
  localparam logic [3:0] DESC_WRITE_HI = 4'h8;
  localparam logic [3:0] DESC_READ_HI  = 4'h9;

  localparam logic [3:0] ADC_MIN_LEN = 4'd5;
  localparam logic [3:0] DAC_MIN_LEN = 4'd3;

  localparam logic [2:0] TX_LEN_WRITE = 3'd5;
  localparam logic [2:0] TX_LEN_READ  = 3'd1;

  localparam logic [15:0] DAC_MID = 16'h8000;

  // adc: quotient by 2^22 - 1
  localparam int          ADC_SHIFT   = 22;
  localparam logic [22:0] ADC_DIVISOR = 23'h3FFFFF;

  // dac readback: 10000000 / 2^15
  localparam logic [30:0] DAC_FULL_SCALE = 31'd10000000;
  localparam int          DAC_SHIFT      = 15;

  // write: x * 256 / 78125 as (x * recip) >> 39, exact for |x| <= 10000305
  localparam logic signed [31:0] WRITE_MAX   = 32'sd9999999;
  localparam logic signed [31:0] WRITE_MIN   = -32'sd10000305;
  localparam logic [30:0]        WRITE_RECIP = 31'd1801439851;
  localparam int                 WRITE_SHIFT = 39;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_ADC,
    OP_DAC_RB,
    OP_WRITE,
    OP_READ
  } op_t;

  // classified item as held in the queue
  typedef struct packed {
    op_t         op;
    logic [5:0]  chan;
    logic        neg;
    logic [23:0] mag;
    logic [1:0]  range_sel;
    logic        ovl;
  } item_t;

  function automatic logic [30:0] adc_range(input logic [1:0] sel);
    logic [30:0] r;
    unique case (sel)
      2'd0: r = 31'd10000000;
      2'd1: r = 31'd1000000;
      2'd2: r = 31'd100000;
      2'd3: r = 31'd10000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/adc_dac_frame_converter.sv =====
// ----------------------------------------------------------------
// adc_dac_frame_converter: adc/dac module frame converter
// turns received frames into readings and write requests into frames
// ----------------------------------------------------------------
// Each transfer on the slave side is a received frame, a dac write request
// or a dac readback request. Received adc frames become a channel, a reading
// in microvolts for one of four ranges and an overload flag; dac readback
// frames become microvolts; a write request clamps its microvolts, encodes a
// 16-bit offset-binary code and gives a write frame followed by a readback
// request frame (tlast on the second). Short frames, unknown descriptors,
// out-of-range channels and an unknown kind give no result. The block takes
// one transfer per cycle while its four-entry queue has room and delivers one
// result per cycle while the master side is not stalled; a write request
// occupies the output register for two result transfers. A result passes the
// queue, the product register, the quotient register and the output register
// before it is valid on the master side, and it transfers when the master side
// is not stalled. The block holds no state between items, and no clearing or
// setup is needed after reset.
module adc_dac_frame_converter #(
  parameter int ADC_CHANNELS = 24,
  parameter int DAC_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  // frame_desc, frame_length, frame_byte1, frame_byte2, frame_byte3,
  // frame_byte4, dac_channel, dac_value
  input  logic [79:0] s_tdata,
  // kind
  input  logic [1:0]  s_tuser,

  output logic        m_tvalid,
  input  logic        m_tready,
  // channel, microvolts, overload, tx_desc, tx_byte1, tx_byte2, tx_length,
  // zero fill
  output logic [63:0] m_tdata,
  // result_kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic           push;
  logic           queue_full;
  logic           q_valid;
  logic           q_pop;
  afc_pkg::item_t front_item;
  afc_pkg::item_t q_item;

  // classify the incoming transfer; dropped items never enter the queue
  afc_front #(
    .ADC_CHANNELS (ADC_CHANNELS),
    .DAC_CHANNELS (DAC_CHANNELS)
  ) u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .queue_full   (queue_full),
    .kind         (s_tuser),
    .frame_desc   (s_tdata[7:0]),
    .frame_length (s_tdata[11:8]),
    .frame_byte1  (s_tdata[19:12]),
    .frame_byte2  (s_tdata[27:20]),
    .frame_byte3  (s_tdata[35:28]),
    .frame_byte4  (s_tdata[43:36]),
    .dac_channel  (s_tdata[47:44]),
    .dac_value    (s_tdata[79:48]),
    .push         (push),
    .item         (front_item)
  );

  // decouples input acceptance from output stalls
  afc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (front_item),
    .full     (queue_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .item_out (q_item)
  );

  // scaling pipeline and result formatting
  afc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sv/afc_front.sv =====
// ----------------------------------------------------------------
// afc_front: input classifier
// decodes one transfer into a queue entry, drops items with no result
// ----------------------------------------------------------------
module afc_front #(
  parameter int ADC_CHANNELS = 24,
  parameter int DAC_CHANNELS = 4
) (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                queue_full,
  input  logic [1:0]          kind,
  input  logic [7:0]          frame_desc,
  input  logic [3:0]          frame_length,
  input  logic [7:0]          frame_byte1,
  input  logic [7:0]          frame_byte2,
  input  logic [7:0]          frame_byte3,
  input  logic [7:0]          frame_byte4,
  input  logic [3:0]          dac_channel,
  input  logic signed [31:0]  dac_value,
  output logic                push,
  output afc_pkg::item_t      item
);

  localparam logic [6:0] ADC_LIMIT = 7'(ADC_CHANNELS);
  localparam logic [4:0] DAC_LIMIT = 5'(DAC_CHANNELS);

  logic [23:0]        raw;
  logic [23:0]        adc_mag;
  logic [15:0]        code16;
  logic [23:0]        dac_mag;
  logic signed [31:0] vc;
  logic signed [31:0] vneg;
  logic [23:0]        wr_mag;
  logic               adc_desc;
  logic               rb_desc;
  logic               dch_ok;
  logic               keep;

  always_comb begin
    raw     = {frame_byte4, frame_byte3, frame_byte2};
    adc_mag = raw[23] ? (~raw + 24'd1) : raw;

    code16  = {frame_byte1, frame_byte2};
    dac_mag = code16[15] ? {8'd0, code16 - afc_pkg::DAC_MID}
                         : {8'd0, afc_pkg::DAC_MID - code16};

    // clamp requested microvolts
    if (dac_value > afc_pkg::WRITE_MAX) begin
      vc = afc_pkg::WRITE_MAX;
    end else if (dac_value < afc_pkg::WRITE_MIN) begin
      vc = afc_pkg::WRITE_MIN;
    end else begin
      vc = dac_value;
    end
    vneg   = -vc;
    wr_mag = vc[31] ? vneg[23:0] : vc[23:0];

    adc_desc = (frame_desc != 8'd0) && (frame_desc[7:2] == 6'd0);
    rb_desc  = (frame_desc[7:4] == afc_pkg::DESC_READ_HI) &&
               ({1'b0, frame_desc[3:0]} < DAC_LIMIT);
    dch_ok   = {1'b0, dac_channel} < DAC_LIMIT;

    item = '0;
    keep = 1'b0;
    unique case (kind)
      afc_pkg::KIND_RX: begin
        priority if (adc_desc) begin
          if (frame_length >= afc_pkg::ADC_MIN_LEN &&
              {1'b0, frame_byte1[5:0]} < ADC_LIMIT) begin
            keep           = 1'b1;
            item.op        = afc_pkg::OP_ADC;
            item.chan      = frame_byte1[5:0];
            item.neg       = raw[23];
            item.mag       = adc_mag;
            item.range_sel = frame_byte1[7:6];
            item.ovl       = adc_mag[23] | adc_mag[22];
          end
        end else if (rb_desc && frame_length >= afc_pkg::DAC_MIN_LEN) begin
          keep      = 1'b1;
          item.op   = afc_pkg::OP_DAC_RB;
          item.chan = {2'd0, frame_desc[3:0]};
          item.neg  = ~code16[15];
          item.mag  = dac_mag;
        end else begin
          // unknown descriptor or short readback frame
          keep = 1'b0;
        end
      end
      afc_pkg::KIND_WRITE: begin
        keep      = dch_ok;
        item.op   = afc_pkg::OP_WRITE;
        item.chan = {2'd0, dac_channel};
        item.neg  = vc[31];
        item.mag  = wr_mag;
      end
      afc_pkg::KIND_READ: begin
        keep      = dch_ok;
        item.op   = afc_pkg::OP_READ;
        item.chan = {2'd0, dac_channel};
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_tready = ~queue_full;
  assign push     = s_tvalid & s_tready & keep;

endmodule

// ===== sv/afc_fifo.sv =====
// ----------------------------------------------------------------
// afc_fifo: item queue
// short register queue between classifier and datapath
// ----------------------------------------------------------------
module afc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  afc_pkg::item_t item_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output afc_pkg::item_t item_out
);

  localparam int AW = $clog2(afc_pkg::QUEUE_DEPTH);

  afc_pkg::item_t entries [afc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full     = count == (AW + 1)'(afc_pkg::QUEUE_DEPTH);
  assign valid    = count != '0;
  assign item_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

endmodule

// ===== sv/afc_back.sv =====
// ----------------------------------------------------------------
// afc_back: scaling datapath and result output
// multiply, constant divide, sign and frame formatting
// ----------------------------------------------------------------
`include "adc_dac_frame_converter_defines.svh"

module afc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  afc_pkg::item_t q_item,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [63:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);

  // stage 1: product
  logic              s1_v;
  afc_pkg::op_t      s1_op;
  logic [5:0]        s1_chan;
  logic              s1_neg;
  logic              s1_ovl;
  logic [54:0]       s1_prod;
  logic [30:0]       mult_k;

  // stage 2: quotient magnitude
  logic              s2_v;
  afc_pkg::op_t      s2_op;
  logic [5:0]        s2_chan;
  logic              s2_neg;
  logic              s2_ovl;
  logic [24:0]       s2_q;
  logic [24:0]       q_next;
  logic [24:0]       q0;
  logic [25:0]       r1;
  logic [3:0]        q1;
  logic [22:0]       r2;
  logic              corr;

  // output stage
  logic              o_v;
  afc_pkg::op_t      o_op;
  logic [5:0]        o_chan;
  logic [25:0]       o_uv;
  logic              o_ovl;
  logic [15:0]       o_code;
  logic              phase;
  logic [25:0]       sq_next;

  logic              o_done;
  logic              o_free;
  logic              s2_ready;
  logic              s1_ready;

  logic [1:0]        rk;
  logic [25:0]       uv;
  logic              ovl;
  logic [7:0]        desc;
  logic [7:0]        b1;
  logic [7:0]        b2;
  logic [2:0]        len;
  logic              last;

  assign o_done   = m_tready & ((o_op != afc_pkg::OP_WRITE) | phase);
  assign o_free   = ~o_v | o_done;
  assign s2_ready = ~s2_v | o_free;
  assign s1_ready = ~s1_v | s2_ready;
  assign q_pop    = q_valid & s1_ready;

  always_comb begin
    unique case (q_item.op)
      afc_pkg::OP_ADC:    mult_k = afc_pkg::adc_range(q_item.range_sel);
      afc_pkg::OP_DAC_RB: mult_k = afc_pkg::DAC_FULL_SCALE;
      afc_pkg::OP_WRITE:  mult_k = afc_pkg::WRITE_RECIP;
      afc_pkg::OP_READ:   mult_k = '0;
    endcase
  end

  // divide by 2^22 - 1 through folding of the high part
  always_comb begin
    q0   = s1_prod[46:afc_pkg::ADC_SHIFT];
    r1   = {4'd0, s1_prod[afc_pkg::ADC_SHIFT-1:0]} + {1'b0, q0};
    q1   = r1[25:afc_pkg::ADC_SHIFT];
    r2   = {1'b0, r1[afc_pkg::ADC_SHIFT-1:0]} + {19'd0, q1};
    corr = r2 >= afc_pkg::ADC_DIVISOR;
    unique case (s1_op)
      afc_pkg::OP_ADC:    q_next = q0 + {21'd0, q1} + {24'd0, corr};
      afc_pkg::OP_DAC_RB: q_next = {1'b0, s1_prod[afc_pkg::DAC_SHIFT+23:afc_pkg::DAC_SHIFT]};
      afc_pkg::OP_WRITE:  q_next = {9'd0, s1_prod[afc_pkg::WRITE_SHIFT+15:afc_pkg::WRITE_SHIFT]};
      afc_pkg::OP_READ:   q_next = '0;
    endcase
  end

  assign sq_next = s2_neg ? -{1'b0, s2_q} : {1'b0, s2_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      o_v   <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v <= q_valid;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
      if (o_free) begin
        o_v   <= s2_v;
        phase <= 1'b0;
      end else if (m_tready && o_op == afc_pkg::OP_WRITE && !phase) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_op   <= q_item.op;
      s1_chan <= q_item.chan;
      s1_neg  <= q_item.neg;
      s1_ovl  <= q_item.ovl;
      s1_prod <= 55'(q_item.mag) * 55'(mult_k);
    end
    if (s2_ready) begin
      s2_op   <= s1_op;
      s2_chan <= s1_chan;
      s2_neg  <= s1_neg;
      s2_ovl  <= s1_ovl;
      s2_q    <= q_next;
    end
    if (o_free) begin
      o_op   <= s2_op;
      o_chan <= s2_chan;
      o_ovl  <= s2_ovl;
      o_uv   <= sq_next;
      o_code <= afc_pkg::DAC_MID + sq_next[15:0];
    end
  end

  always_comb begin
    rk   = afc_pkg::RK_TX;
    uv   = '0;
    ovl  = 1'b0;
    desc = {afc_pkg::DESC_READ_HI, o_chan[3:0]};
    b1   = '0;
    b2   = '0;
    len  = afc_pkg::TX_LEN_READ;
    last = 1'b1;
    unique case (o_op)
      afc_pkg::OP_ADC: begin
        rk   = afc_pkg::RK_ADC;
        uv   = o_uv;
        ovl  = o_ovl;
        desc = '0;
        len  = '0;
      end
      afc_pkg::OP_DAC_RB: begin
        rk   = afc_pkg::RK_DAC;
        uv   = o_uv;
        desc = '0;
        len  = '0;
      end
      afc_pkg::OP_WRITE: begin
        if (!phase) begin
          desc = {afc_pkg::DESC_WRITE_HI, o_chan[3:0]};
          b1   = o_code[15:8];
          b2   = o_code[7:0];
          len  = afc_pkg::TX_LEN_WRITE;
          last = 1'b0;
        end
      end
      afc_pkg::OP_READ: last = 1'b1;
    endcase
  end

  assign m_tvalid = o_v;
  assign m_tuser  = rk;
  assign m_tlast  = last;
  assign m_tdata  = {4'd0, len, b2, b1, desc, ovl, uv, o_chan};

  `AFC_ASSERT(a_phase_write, phase |-> (o_v && o_op == afc_pkg::OP_WRITE), "second phase on a non-write result")
  `AFC_ASSERT_NEXT(a_write_pair, (o_v && m_tready && o_op == afc_pkg::OP_WRITE && !phase), (o_v && phase), "readback frame did not follow write frame")
  `AFC_ASSERT(a_adc_quot, (s2_v && s2_op == afc_pkg::OP_ADC) |-> (s2_q <= 25'd20000005), "adc quotient out of range")
  `AFC_ASSERT(a_write_quot, (s2_v && s2_op == afc_pkg::OP_WRITE) |-> (s2_q <= 25'd32768), "dac code quotient out of range")

endmodule

// ===== sim/adc_dac_frame_converter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------
// adc_dac_frame_converter_tb: frame converter testbench
// directed frames and requests, then random traffic under idling and
// a long output stall; every result is checked against a local model
// ----------------------------------------------------------------
module adc_dac_frame_converter_tb;

  localparam int ADC_CHANNELS = 24;
  localparam int DAC_CHANNELS = 4;

  // scaling constants of the conversions
  localparam longint ADC_CODE_MAX   = 64'sh3FFFFF;
  localparam longint ADC_TOP_SPAN   = 64'sd10000000;
  localparam longint DAC_SCALE      = 64'sd10000000;
  localparam longint DAC_MID_CODE   = 64'sh8000;
  localparam longint WRITE_CLAMP_HI = 64'sd9999999;
  localparam longint WRITE_CLAMP_LO = -64'sd10000305;

  // adc frame descriptors
  localparam logic [7:0] ADC_DESC_FIRST = 8'd1;
  localparam logic [7:0] ADC_DESC_LAST  = 8'd3;
  localparam logic [1:0] KIND_UNKNOWN   = 2'd3;

  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 480;
  localparam int HOLD_CYCLES   = 150;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         desc;
    logic [3:0]         len;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;
    logic [7:0]         b4;
    logic [3:0]         dch;
    logic signed [31:0] value;
  } frame_item_t;

  typedef struct packed {
    logic [1:0]         rkind;
    logic [5:0]         chan;
    logic signed [25:0] uv;
    logic               ovl;
    logic [7:0]         desc;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [2:0]         len;
    logic               last;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  reading_t pending_readings[$];
  int error_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_cycles;

  adc_dac_frame_converter #(
    .ADC_CHANNELS(ADC_CHANNELS),
    .DAC_CHANNELS(DAC_CHANNELS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // expected results of one accepted item, appended to the pending queue
  function automatic int convert_item(input frame_item_t it);
    reading_t r;
    longint code;
    longint span;
    longint v;
    logic [23:0] raw;
    logic [15:0] dac_code;
    int n;
    r = '0;
    n = 0;
    case (it.kind)
      afc_pkg::KIND_RX: begin
        if (it.desc >= ADC_DESC_FIRST && it.desc <= ADC_DESC_LAST) begin
          if (it.len >= afc_pkg::ADC_MIN_LEN && it.b1[5:0] < ADC_CHANNELS) begin
            raw = {it.b4, it.b3, it.b2};
            code = longint'($signed(raw));
            // range code steps the full scale down by decades
            span = ADC_TOP_SPAN;
            for (int i = 0; i < it.b1[7:6]; i++) span = span / 10;
            v = code * span / ADC_CODE_MAX;
            r.rkind = afc_pkg::RK_ADC;
            r.chan = it.b1[5:0];
            r.uv = v[25:0];
            r.ovl = (code > ADC_CODE_MAX) || (code < -ADC_CODE_MAX);
            r.last = 1'b1;
            pending_readings.push_back(r);
            n = 1;
          end
        end else if (it.desc[7:4] == afc_pkg::DESC_READ_HI &&
                     it.desc[3:0] < DAC_CHANNELS) begin
          if (it.len >= afc_pkg::DAC_MIN_LEN) begin
            code = {48'd0, it.b1, it.b2};
            v = (code - DAC_MID_CODE) * DAC_SCALE / DAC_MID_CODE;
            r.rkind = afc_pkg::RK_DAC;
            r.chan = {2'b00, it.desc[3:0]};
            r.uv = v[25:0];
            r.last = 1'b1;
            pending_readings.push_back(r);
            n = 1;
          end
        end
      end
      afc_pkg::KIND_WRITE, afc_pkg::KIND_READ: begin
        if (it.dch < DAC_CHANNELS) begin
          r.rkind = afc_pkg::RK_TX;
          r.chan = {2'b00, it.dch};
          if (it.kind == afc_pkg::KIND_WRITE) begin
            v = longint'(it.value);
            if (v > WRITE_CLAMP_HI) v = WRITE_CLAMP_HI;
            if (v < WRITE_CLAMP_LO) v = WRITE_CLAMP_LO;
            code = v * DAC_MID_CODE / DAC_SCALE + DAC_MID_CODE;
            dac_code = code[15:0];
            r.desc = {afc_pkg::DESC_WRITE_HI, it.dch};
            r.b1 = dac_code[15:8];
            r.b2 = dac_code[7:0];
            r.len = afc_pkg::TX_LEN_WRITE;
            r.last = 1'b0;
            pending_readings.push_back(r);
            n++;
          end
          // readback request follows every write and stands alone for a read
          r.desc = {afc_pkg::DESC_READ_HI, it.dch};
          r.b1 = 8'd0;
          r.b2 = 8'd0;
          r.len = afc_pkg::TX_LEN_READ;
          r.last = 1'b1;
          pending_readings.push_back(r);
          n++;
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic frame_item_t make_item(input logic [1:0] kind, input logic [7:0] desc,
                                            input logic [3:0] len, input logic [7:0] b1,
                                            input logic [23:0] code, input logic [3:0] dch,
                                            input logic signed [31:0] value);
    frame_item_t it;
    it.kind = kind;
    it.desc = desc;
    it.len = len;
    it.b1 = b1;
    {it.b4, it.b3, it.b2} = code;
    it.dch = dch;
    it.value = value;
    return it;
  endfunction

  function automatic frame_item_t random_item();
    frame_item_t it;
    int sel;
    it.kind = 2'($urandom_range(3));
    it.desc = 8'($urandom);
    it.len = 4'($urandom_range(15));
    it.b1 = 8'($urandom);
    it.b2 = 8'($urandom);
    it.b3 = 8'($urandom);
    it.b4 = 8'($urandom);
    it.dch = 4'($urandom_range(15));
    it.value = $urandom;
    sel = $urandom_range(99);
    if (sel < 35) begin
      // well-formed adc frame, random code and range
      it.kind = afc_pkg::KIND_RX;
      it.desc = 8'($urandom_range(ADC_DESC_LAST, ADC_DESC_FIRST));
      it.len = 4'($urandom_range(15, afc_pkg::ADC_MIN_LEN));
      it.b1[5:0] = 6'($urandom_range(ADC_CHANNELS - 1));
      if ($urandom_range(3) == 0) it.b4[7:6] = {2{it.b4[5]}};
    end else if (sel < 50) begin
      it.kind = afc_pkg::KIND_RX;
      it.desc = {afc_pkg::DESC_READ_HI, 4'($urandom_range(DAC_CHANNELS - 1))};
      it.len = 4'($urandom_range(15, afc_pkg::DAC_MIN_LEN));
    end else if (sel < 70) begin
      it.kind = afc_pkg::KIND_WRITE;
      it.dch = 4'($urandom_range(DAC_CHANNELS - 1));
      // half within a little beyond the clamp range, half anywhere
      if ($urandom_range(1) == 0)
        it.value = $signed($urandom_range(20000800)) - 32'sd10000400;
    end else if (sel < 80) begin
      it.kind = afc_pkg::KIND_READ;
      it.dch = 4'($urandom_range(DAC_CHANNELS - 1));
    end
    return it;
  endfunction

  // offer one item with random idle cycles in front, predict on transfer
  task automatic send_item(input frame_item_t it, output int n_results);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {it.value, it.dch, it.b4, it.b3, it.b2, it.b1, it.len, it.desc};
    do @(posedge clk); while (!s_tready);
    n_results = convert_item(it);
  endtask

  task automatic test_directed();
    frame_item_t items[$];
    int n;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    // adc: each descriptor and range, code extremes and overload edges
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd1, 4'd5, {2'd0, 6'd0}, 24'h3FFFFF, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd2, 4'd8, {2'd1, 6'd23}, 24'h400000, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd3, 4'd15, {2'd2, 6'd5}, 24'h7FFFFF, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd1, 4'd6, {2'd3, 6'd10}, 24'h800000, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd2, 4'd5, {2'd0, 6'd1}, 24'hC00001, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd3, 4'd5, {2'd3, 6'd2}, 24'hC00000, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd3, 4'd5, {2'd1, 6'd3}, 24'h000000, 4'd0, 0));
    // adc channel out of range, short frame, unknown descriptors
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd1, 4'd5, {2'd0, 6'd24}, 24'h000100, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd1, 4'd5, {2'd3, 6'd63}, 24'h000100, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd2, 4'd4, {2'd0, 6'd4}, 24'h000100, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd0, 4'd8, 8'd0, 24'h000100, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'd4, 4'd8, 8'd0, 24'h000100, 4'd0, 0));
    // dac readback frames
    items.push_back(make_item(afc_pkg::KIND_RX, 8'h90, 4'd3, 8'h00, 24'h000000, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'h93, 4'd8, 8'hFF, 24'h0000FF, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'h91, 4'd3, 8'h80, 24'h000000, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'h94, 4'd3, 8'h80, 24'h000000, 4'd0, 0));
    items.push_back(make_item(afc_pkg::KIND_RX, 8'h90, 4'd2, 8'h80, 24'h000000, 4'd0, 0));
    // write requests across the clamp limits
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd0, 32'sd0));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd3,
                              32'sh7FFFFFFF));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd1,
                              32'sh80000000));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd2,
                              32'sd9999999));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd2,
                              32'sd10000000));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd1,
                              -32'sd10000305));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd0,
                              -32'sd10000306));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd4, 32'sd1000));
    items.push_back(make_item(afc_pkg::KIND_WRITE, 8'd0, 4'd0, 8'd0, 24'd0, 4'd15, 32'sd1000));
    // readback requests and the unknown kind
    items.push_back(make_item(afc_pkg::KIND_READ, 8'd0, 4'd0, 8'd0, 24'd0, 4'd3, 0));
    items.push_back(make_item(afc_pkg::KIND_READ, 8'd0, 4'd0, 8'd0, 24'd0, 4'd4, 0));
    items.push_back(make_item(KIND_UNKNOWN, 8'd1, 4'd8, 8'd0, 24'd0, 4'd0, 0));
    foreach (items[i]) send_item(items[i], n);
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
    frame_item_t it;
    int counted;
    int n;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    counted = 0;
    while (counted < n_items) begin
      it = random_item();
      send_item(it, n);
      if (n > 0) counted++;
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    frame_item_t it;
    int n;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      it = random_item();
      send_item(it, n);
    end
  endtask

  // receiver side: long hold-off first, otherwise random stalls
  initial begin
    m_tready = 1'b0;
    hold_cycles = 0;
    rx_stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      error_count++;
    end
  endtask

  // compare every output transfer with the oldest pending reading
  always @(posedge clk) begin
    reading_t r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result transfer, tdata %h", m_tdata);
        error_count++;
      end else begin
        r = pending_readings.pop_front();
        check_field("result_kind", longint'(r.rkind), longint'(m_tuser));
        check_field("channel", longint'(r.chan), longint'(m_tdata[5:0]));
        check_field("microvolts", longint'(r.uv), longint'($signed(m_tdata[31:6])));
        check_field("overload", longint'(r.ovl), longint'(m_tdata[32]));
        check_field("tx_desc", longint'(r.desc), longint'(m_tdata[40:33]));
        check_field("tx_byte1", longint'(r.b1), longint'(m_tdata[48:41]));
        check_field("tx_byte2", longint'(r.b2), longint'(m_tdata[56:49]));
        check_field("tx_length", longint'(r.len), longint'(m_tdata[59:57]));
        check_field("zero_fill", 64'sd0, longint'(m_tdata[63:60]));
        check_field("last", longint'(r.last), longint'(m_tlast));
      end
    end
  end

  initial begin
    error_count = 0;
    tx_idle_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(25, 66, RANDOM_ITEMS);
    test_random(66, 25, RANDOM_ITEMS);
    test_random(0, 0, RANDOM_ITEMS);
    test_backpressure();

    @(negedge clk);
    s_tvalid <= 1'b0;
    rx_stall_pct = 0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
